[src/segx_pkg.sv]
// ----------------------------------------------------------------------------
// segx_pkg: shared types and constants for the segment intersection block
// Result status codes and the fixed result field widths.
// ----------------------------------------------------------------------------
package segx_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int DELTA_W         = 17;
  localparam int DELTA_MAX       = 65535;
  localparam int STATUS_W        = 2;
  localparam int OUT_TDATA_W     = 40;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_T_OUT    = 2'd2,
    ST_U_OUT    = 2'd3
  } status_t;

endpackage

[src/segment_intersection_delta_top.sv]
// ----------------------------------------------------------------------------
// segment_intersection_delta_top: exact two-segment intersection offset
// Pipelined cross-product intersection test with a bit-serial divider chain.
// ----------------------------------------------------------------------------
// Order: differences, products, den/tn/un, range checks, divider, output reg.
// Throughput: one transaction per cycle when not stalled; the divider is
//   unrolled, one stage per quotient bit; COORD_WIDTH+1 stages set depth.
// Stall: the whole pipeline holds while the output register is full and
//   not taken. Reset (rst_n low, synchronous) clears all valid bits.
module segment_intersection_delta_top #(
  parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
  // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y (lowest first)
  input  logic [8*COORD_WIDTH-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // status [1:0], delta_x [18:2], delta_y [35:19], zero pad [39:36]
  output logic [segx_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import segx_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;          // coordinate difference
  localparam int PW = 2 * DW;          // product
  localparam int NW = PW + 1;          // den / tn / un
  localparam int RW = NW + 1;          // divider partial remainder
  localparam int QW = (DW > DELTA_W) ? DW : DELTA_W;

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---- stage 1: coordinate differences ------------------------------------
  logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = $signed(in_tdata[0*CW +: CW]);
  assign y1 = $signed(in_tdata[1*CW +: CW]);
  assign x2 = $signed(in_tdata[2*CW +: CW]);
  assign y2 = $signed(in_tdata[3*CW +: CW]);
  assign x3 = $signed(in_tdata[4*CW +: CW]);
  assign y3 = $signed(in_tdata[5*CW +: CW]);
  assign x4 = $signed(in_tdata[6*CW +: CW]);
  assign y4 = $signed(in_tdata[7*CW +: CW]);

  logic                 s1_v_r;
  logic signed [DW-1:0] dax_r, day_r, dbx_r, dby_r, d13x_r, d13y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
    end
    if (adv) begin
      dax_r  <= DW'(x1) - DW'(x2);
      day_r  <= DW'(y1) - DW'(y2);
      dbx_r  <= DW'(x3) - DW'(x4);
      dby_r  <= DW'(y3) - DW'(y4);
      d13x_r <= DW'(x1) - DW'(x3);
      d13y_r <= DW'(y1) - DW'(y3);
    end
  end

  // ---- stage 2: six products ----------------------------------------------
  logic                 s2_v_r;
  logic signed [PW-1:0] pda_r, pdb_r, pta_r, ptb_r, pua_r, pub_r;
  logic signed [DW-1:0] s2_dax_r, s2_day_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
    if (adv) begin
      pda_r    <= dax_r * dby_r;
      pdb_r    <= day_r * dbx_r;
      pta_r    <= d13x_r * dby_r;
      ptb_r    <= d13y_r * dbx_r;
      pua_r    <= day_r * d13x_r;
      pub_r    <= dax_r * d13y_r;
      s2_dax_r <= dax_r;
      s2_day_r <= day_r;
    end
  end

  // ---- stage 3: den, tn, un -----------------------------------------------
  logic                 s3_v_r;
  logic signed [NW-1:0] den_r, tn_r, un_r;
  logic signed [DW-1:0] s3_dax_r, s3_day_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
    if (adv) begin
      den_r    <= NW'(pda_r) - NW'(pdb_r);
      tn_r     <= NW'(pta_r) - NW'(ptb_r);
      un_r     <= NW'(pua_r) - NW'(pub_r);
      s3_dax_r <= s2_dax_r;
      s3_day_r <= s2_day_r;
    end
  end

  // ---- stage 4: range checks, magnitudes ----------------------------------
  logic [NW-1:0] den_mag, tn_mag, un_mag;
  logic          t_ok, u_ok;
  status_t       st_nxt;

  assign den_mag = den_r[NW-1] ? NW'(-den_r) : NW'(den_r);
  assign tn_mag  = tn_r[NW-1]  ? NW'(-tn_r)  : NW'(tn_r);
  assign un_mag  = un_r[NW-1]  ? NW'(-un_r)  : NW'(un_r);
  // ratio in [0,1]: zero numerator, or same sign and not larger magnitude
  assign t_ok = (tn_r == '0) || ((tn_r[NW-1] == den_r[NW-1]) && (den_mag >= tn_mag));
  assign u_ok = (un_r == '0) || ((un_r[NW-1] == den_r[NW-1]) && (den_mag >= un_mag));

  always_comb begin
    priority if (den_r == '0) begin
      st_nxt = ST_PARALLEL;
    end else if (!t_ok) begin
      st_nxt = ST_T_OUT;
    end else if (!u_ok) begin
      st_nxt = ST_U_OUT;
    end else begin
      st_nxt = ST_HIT;
    end
  end

  // ---- divider chain: index 0 is stage 4, one quotient bit per stage -------
  // extent x2-x1 = -dax, so it is negative when dax is positive
  logic          dv_v_r  [0:DW];
  status_t       dv_st_r [0:DW];
  logic [NW-1:0] dv_t_r  [0:DW];
  logic [NW-1:0] dv_d_r  [0:DW];
  logic [DW-1:0] dv_ex_r [0:DW];
  logic [DW-1:0] dv_ey_r [0:DW];
  logic          dv_nx_r [0:DW];
  logic          dv_ny_r [0:DW];
  logic [NW-1:0] dv_rx_r [0:DW];
  logic [NW-1:0] dv_ry_r [0:DW];
  logic [DW-1:0] dv_qx_r [0:DW];
  logic [DW-1:0] dv_qy_r [0:DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= s3_v_r;
    end
    if (adv) begin
      dv_st_r[0] <= st_nxt;
      dv_t_r[0]  <= tn_mag;
      dv_d_r[0]  <= den_mag;
      dv_ex_r[0] <= s3_dax_r[DW-1] ? DW'(-s3_dax_r) : DW'(s3_dax_r);
      dv_ey_r[0] <= s3_day_r[DW-1] ? DW'(-s3_day_r) : DW'(s3_day_r);
      dv_nx_r[0] <= !s3_dax_r[DW-1] && (s3_dax_r != '0);
      dv_ny_r[0] <= !s3_day_r[DW-1] && (s3_day_r != '0);
      dv_rx_r[0] <= '0;
      dv_ry_r[0] <= '0;
      dv_qx_r[0] <= '0;
      dv_qy_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [RW-1:0] d1, d2, rx2, ry2;
    logic [NW-1:0] rx_nxt, ry_nxt;
    logic [1:0]    kx, ky;

    assign d1 = RW'(dv_d_r[k]);
    assign d2 = d1 << 1;

    // rem*2 + (bit ? t : 0) stays below 3*d since t <= d
    always_comb begin
      rx2 = (RW'(dv_rx_r[k]) << 1) + (dv_ex_r[k][DW-1-k] ? RW'(dv_t_r[k]) : '0);
      ry2 = (RW'(dv_ry_r[k]) << 1) + (dv_ey_r[k][DW-1-k] ? RW'(dv_t_r[k]) : '0);
      priority if (rx2 >= d2) begin
        rx_nxt = NW'(rx2 - d2);
        kx     = 2'd2;
      end else if (rx2 >= d1) begin
        rx_nxt = NW'(rx2 - d1);
        kx     = 2'd1;
      end else begin
        rx_nxt = NW'(rx2);
        kx     = 2'd0;
      end
      priority if (ry2 >= d2) begin
        ry_nxt = NW'(ry2 - d2);
        ky     = 2'd2;
      end else if (ry2 >= d1) begin
        ry_nxt = NW'(ry2 - d1);
        ky     = 2'd1;
      end else begin
        ry_nxt = NW'(ry2);
        ky     = 2'd0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      if (adv) begin
        dv_st_r[k+1] <= dv_st_r[k];
        dv_t_r[k+1]  <= dv_t_r[k];
        dv_d_r[k+1]  <= dv_d_r[k];
        dv_ex_r[k+1] <= dv_ex_r[k];
        dv_ey_r[k+1] <= dv_ey_r[k];
        dv_nx_r[k+1] <= dv_nx_r[k];
        dv_ny_r[k+1] <= dv_ny_r[k];
        dv_rx_r[k+1] <= rx_nxt;
        dv_ry_r[k+1] <= ry_nxt;
        dv_qx_r[k+1] <= (dv_qx_r[k] << 1) + DW'(kx);
        dv_qy_r[k+1] <= (dv_qy_r[k] << 1) + DW'(ky);
      end
    end
  end

  // ---- output register: saturate, sign, zero on miss ------------------------
  logic [QW-1:0]      qx_z, qy_z;
  logic [DELTA_W-1:0] mx, my, dx_nxt, dy_nxt;
  logic               hit;
  logic               out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign qx_z = QW'(dv_qx_r[DW]);
  assign qy_z = QW'(dv_qy_r[DW]);
  assign mx   = (qx_z > QW'(DELTA_MAX)) ? DELTA_W'(DELTA_MAX) : qx_z[DELTA_W-1:0];
  assign my   = (qy_z > QW'(DELTA_MAX)) ? DELTA_W'(DELTA_MAX) : qy_z[DELTA_W-1:0];
  assign hit  = (dv_st_r[DW] == ST_HIT);
  assign dx_nxt = !hit ? '0 : (dv_nx_r[DW] ? -mx : mx);
  assign dy_nxt = !hit ? '0 : (dv_ny_r[DW] ? -my : my);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= dv_v_r[DW];
    end
    if (adv) begin
      out_tdata_r <= {(OUT_TDATA_W - STATUS_W - 2*DELTA_W)'(0), dy_nxt, dx_nxt,
                      dv_st_r[DW]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---- assertions ----------------------------------------------------------
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[STATUS_W-1:0] != ST_HIT) |->
      (out_tdata[STATUS_W +: 2*DELTA_W] == '0))
    else $error("nonzero delta on a miss");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && !in_tready || out_tready)
    else $error("output dropped while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow output stall");

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for segment_intersection_delta_top
// Drives segment pairs on the input stream and checks every result transaction
// against an exact integer intersection predictor. A directed table runs first,
// then random traffic with random idle bursts on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import segx_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int N_RANDOM = 480;
  localparam int N_QUIET = 60;     // tail of the run with no idling
  localparam int DRAIN_CYCLES = 3 * (CW + 6);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0] delta_t;

  typedef struct {
    status_t status;
    delta_t  dx;
    delta_t  dy;
  } isect_t;

  // one row of the directed table; fixed rows carry a typed-in result
  typedef struct {
    coord_t c[8];
    bit     fixed;
    isect_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [8*CW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  isect_t pending_q[$];   // results still owed by the block
  int errors = 0;
  bit idle_on = 1'b1;

  segment_intersection_delta_top #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // n/d inside [0,1] by sign and magnitude, d nonzero
  function automatic bit in_unit(longint n, longint d);
    if (n == 0) return 1'b1;
    if ((n < 0) != (d < 0)) return 1'b0;
    return (d < 0 ? -d : d) >= (n < 0 ? -n : n);
  endfunction

  // t*ext truncated toward zero, magnitude saturated at DELTA_MAX
  function automatic delta_t scale_extent(longint tn, longint ext, longint den);
    longint q;
    q = ((tn < 0 ? -tn : tn) * (ext < 0 ? -ext : ext)) / (den < 0 ? -den : den);
    if (q > DELTA_MAX) q = DELTA_MAX;
    if (ext < 0) q = -q;
    return delta_t'(q);
  endfunction

  function automatic isect_t predict_isect(coord_t c[8]);
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint dax, day, dbx, dby, d13x, d13y, den, tn, un;
    isect_t r;
    x1 = c[0]; y1 = c[1]; x2 = c[2]; y2 = c[3];
    x3 = c[4]; y3 = c[5]; x4 = c[6]; y4 = c[7];
    dax = x1 - x2; day = y1 - y2; dbx = x3 - x4; dby = y3 - y4;
    d13x = x1 - x3; d13y = y1 - y3;
    den = dax * dby - day * dbx;
    tn = d13x * dby - d13y * dbx;
    un = day * d13x - dax * d13y;
    r = '{ST_HIT, '0, '0};
    if (den == 0) r.status = ST_PARALLEL;
    else if (!in_unit(tn, den)) r.status = ST_T_OUT;
    else if (!in_unit(un, den)) r.status = ST_U_OUT;
    else begin
      r.dx = scale_extent(tn, x2 - x1, den);
      r.dy = scale_extent(tn, y2 - y1, den);
    end
    return r;
  endfunction

  // one input transaction; the owed result is queued at acceptance
  task automatic send_pair(coord_t c[8], isect_t res);
    logic [8*CW-1:0] packed_in;
    for (int i = 0; i < 8; i++) packed_in[i*CW +: CW] = c[i];
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= packed_in;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pending_q.push_back(res);
  endtask

  // result side: random stall bursts, none once idling is switched off
  int stall_left = 0;
  always @(posedge clk) begin
    if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest owed result
  always @(posedge clk) begin
    isect_t want;
    status_t got_st;
    delta_t got_dx, got_dy;
    if (rst_n && out_tvalid && out_tready) begin
      got_st = status_t'(out_tdata[1:0]);
      got_dx = out_tdata[18:2];
      got_dy = out_tdata[35:19];
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d dx=%0d dy=%0d",
                 $time, got_st, got_dx, got_dy);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got_st !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got_st);
          errors++;
        end
        if (got_dx !== want.dx) begin
          $display("%0t: delta_x expected %0d actual %0d", $time, want.dx, got_dx);
          errors++;
        end
        if (got_dy !== want.dy) begin
          $display("%0t: delta_y expected %0d actual %0d", $time, want.dy, got_dy);
          errors++;
        end
      end
    end
  end

  function automatic coord_t rnd_full();
    return coord_t'($urandom());
  endfunction

  // two segments crossing at a shared point, with random reach on each side
  function automatic void make_crossing(ref coord_t c[8]);
    int px, py, vx, vy;
    px = $urandom_range(0, 40000) - 20000;
    py = $urandom_range(0, 40000) - 20000;
    for (int s = 0; s < 2; s++) begin
      vx = $urandom_range(0, 200) - 100;
      vy = $urandom_range(0, 200) - 100;
      c[4*s]   = coord_t'(px - vx * $urandom_range(0, 50));
      c[4*s+1] = coord_t'(py - vy * $urandom_range(0, 50));
      c[4*s+2] = coord_t'(px + vx * $urandom_range(0, 50));
      c[4*s+3] = coord_t'(py + vy * $urandom_range(0, 50));
    end
  endfunction

  row_t directed[] = '{
    // all points equal: degenerate, parallel
    '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{ST_PARALLEL, 0, 0}},
    // plain crossing at the middle of A
    '{'{0, 0, 10, 0, 5, -5, 5, 5}, 1'b1, '{ST_HIT, 5, 0}},
    // B right of A's end: t beyond one
    '{'{0, 0, 10, 0, 20, -5, 20, 5}, 1'b1, '{ST_T_OUT, 0, 0}},
    // B above A: u below zero
    '{'{0, 0, 10, 0, 5, 1, 5, 5}, 1'b1, '{ST_U_OUT, 0, 0}},
    // collinear overlapping segments
    '{'{0, 0, 10, 10, 2, 2, 20, 20}, 1'b1, '{ST_PARALLEL, 0, 0}},
    // crossing at A's start (t zero)
    '{'{0, 0, 10, 0, 0, -5, 0, 5}, 1'b1, '{ST_HIT, 0, 0}},
    // crossing at A's end (t one)
    '{'{0, 0, 10, 0, 10, -5, 10, 5}, 1'b1, '{ST_HIT, 10, 0}},
    // touching at B's ends (u zero, u one)
    '{'{0, 0, 10, 0, 4, 0, 4, 7}, 1'b0, '{ST_HIT, 0, 0}},
    '{'{0, 0, 10, 0, 4, 7, 4, 0}, 1'b0, '{ST_HIT, 0, 0}},
    // full-range diagonals
    '{'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
      1'b0, '{ST_HIT, 0, 0}},
    '{'{32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767},
      1'b0, '{ST_HIT, 0, 0}},
    '{'{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767},
      1'b0, '{ST_HIT, 0, 0}},
    // extremes on one axis, truncation toward zero with negative extent
    '{'{32767, 0, -32768, 0, 1, -3, 1, 7}, 1'b0, '{ST_HIT, 0, 0}},
    '{'{0, 32767, 0, -32768, -1, -1, 3, 2}, 1'b0, '{ST_HIT, 0, 0}},
    '{'{0, 0, -7, -3, -5, 0, 0, -3}, 1'b0, '{ST_HIT, 0, 0}},
    // parallel but apart, at the range limits
    '{'{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767},
      1'b1, '{ST_PARALLEL, 0, 0}},
    // t negative, u out with extreme coordinates
    '{'{0, 0, 10, 0, -20, -5, -20, 5}, 1'b1, '{ST_T_OUT, 0, 0}},
    '{'{-32768, 0, 32767, 0, 0, 32767, 1, 1}, 1'b0, '{ST_HIT, 0, 0}},
    // negative denominator, hit
    '{'{10, 0, 0, 0, 5, -5, 5, 5}, 1'b1, '{ST_HIT, -5, 0}}
  };

  initial begin
    coord_t c[8];
    int pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[r])
      send_pair(directed[r].c,
                directed[r].fixed ? directed[r].res : predict_isect(directed[r].c));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_QUIET) idle_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        make_crossing(c);
      end else if (pick < 8) begin
        foreach (c[i]) c[i] = rnd_full();
      end else begin
        // tiny grid: many parallel and degenerate pairs
        foreach (c[i]) c[i] = coord_t'($urandom_range(0, 6) - 3);
      end
      send_pair(c, predict_isect(c));
    end
    in_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
src/segx_pkg.sv
src/segment_intersection_delta_top.sv
sim/tb_top.sv
